[rtl/rtc_pkg.sv]
package rtc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int ID_BITS   = 16;
  localparam int COORD_W   = 32;
  localparam int DIFF_W    = COORD_W + 1;
  localparam int MC_W      = 2 * DIFF_W + 2;
  localparam int ACC_W     = 104;
  localparam int NUM_W     = ACC_W + FRAC_BITS;
  localparam int DCNT_W    = $clog2(NUM_W);
  localparam int DIST_W    = 31;
  localparam int BARY_W    = 17;
  localparam int Q_W       = 32;
  localparam int NSTEPS    = 24;
  localparam int STEP_W    = $clog2(NSTEPS);
  localparam int BIT_W     = $clog2(DIFF_W);
  localparam int SEL_W     = 4;
  localparam int CFG_IDX_W = 3;
  localparam int QDEPTH    = 2;
  localparam int QPTR_W    = $clog2(QDEPTH);
  localparam int QCNT_W    = $clog2(QDEPTH + 1);

  localparam logic [Q_W-1:0] DIST_CAP = Q_W'((64'd1 << DIST_W) - 64'd1);
  localparam logic [Q_W-1:0] BARY_CAP = Q_W'((64'd1 << BARY_W) - 64'd1);

  localparam logic [CFG_IDX_W-1:0] CFG_ORIG_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIG_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ORIG_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_X  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Y  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DIR_Z  = 3'd5;

  // multiplicand pool: dir, s, p, q
  localparam logic [SEL_W-1:0] MC_DIR = 4'd0;
  localparam logic [SEL_W-1:0] MC_S   = 4'd3;
  localparam logic [SEL_W-1:0] MC_P   = 4'd6;
  localparam logic [SEL_W-1:0] MC_Q   = 4'd9;
  // multiplier pool: e1, e2, s, dir
  localparam logic [SEL_W-1:0] MP_E1  = 4'd0;
  localparam logic [SEL_W-1:0] MP_E2  = 4'd3;
  localparam logic [SEL_W-1:0] MP_S   = 4'd6;
  localparam logic [SEL_W-1:0] MP_DIR = 4'd9;
  // accumulation targets
  localparam logic [SEL_W-1:0] DST_P   = 4'd0;
  localparam logic [SEL_W-1:0] DST_Q   = 4'd3;
  localparam logic [SEL_W-1:0] DST_DET = 4'd6;
  localparam logic [SEL_W-1:0] DST_NT  = 4'd7;
  localparam logic [SEL_W-1:0] DST_NU  = 4'd8;
  localparam logic [SEL_W-1:0] DST_NV  = 4'd9;

  typedef struct packed {
    logic [COORD_W-1:0] vert0_x;
    logic [COORD_W-1:0] vert0_y;
    logic [COORD_W-1:0] vert0_z;
    logic [COORD_W-1:0] vert1_x;
    logic [COORD_W-1:0] vert1_y;
    logic [COORD_W-1:0] vert1_z;
    logic [COORD_W-1:0] vert2_x;
    logic [COORD_W-1:0] vert2_y;
    logic [COORD_W-1:0] vert2_z;
    logic [ID_BITS-1:0] tri_id;
    logic               end_of_search;
  } tri_in_t;

  typedef struct packed {
    logic               hit_found;
    logic               closer;
    logic               front_face;
    logic [DIST_W-1:0]  hit_distance;
    logic [BARY_W-1:0]  bary_u;
    logic [BARY_W-1:0]  bary_v;
    logic [DIST_W-1:0]  best_distance_out;
    logic [ID_BITS-1:0] best_id_out;
    logic               any_hit_out;
    logic               search_done;
  } hit_out_t;

  typedef struct packed {
    logic [2:0][DIFF_W-1:0] e1;
    logic [2:0][DIFF_W-1:0] e2;
    logic [2:0][DIFF_W-1:0] s;
    logic [ID_BITS-1:0]     id;
    logic                   last;
  } work_t;

  typedef struct packed {
    logic [SEL_W-1:0] mc_sel;
    logic [SEL_W-1:0] mp_sel;
    logic             neg;
    logic             last;
    logic [SEL_W-1:0] dst;
  } step_t;

  typedef enum logic [2:0] {
    B_IDLE, B_LOAD, B_MAC, B_NORM, B_CHECK, B_DIV_GO, B_DIV_WAIT, B_DONE
  } back_state_t;

  function automatic step_t mk(input logic [SEL_W-1:0] mc, input logic [SEL_W-1:0] mp,
                               input logic neg, input logic last,
                               input logic [SEL_W-1:0] dst);
    step_t r;
    r.mc_sel = mc;
    r.mp_sel = mp;
    r.neg    = neg;
    r.last   = last;
    r.dst    = dst;
    return r;
  endfunction

  // p = dir x e2, q = s x e1, det = p.e1, nt = q.e2, nu = p.s, nv = q.dir
  function automatic step_t step_rom(input logic [STEP_W-1:0] idx);
    step_t r;
    case (idx)
      5'd0:  r = mk(MC_DIR + 4'd1, MP_E2 + 4'd2, 1'b0, 1'b0, DST_P);
      5'd1:  r = mk(MC_DIR + 4'd2, MP_E2 + 4'd1, 1'b1, 1'b1, DST_P);
      5'd2:  r = mk(MC_DIR + 4'd2, MP_E2 + 4'd0, 1'b0, 1'b0, DST_P + 4'd1);
      5'd3:  r = mk(MC_DIR + 4'd0, MP_E2 + 4'd2, 1'b1, 1'b1, DST_P + 4'd1);
      5'd4:  r = mk(MC_DIR + 4'd0, MP_E2 + 4'd1, 1'b0, 1'b0, DST_P + 4'd2);
      5'd5:  r = mk(MC_DIR + 4'd1, MP_E2 + 4'd0, 1'b1, 1'b1, DST_P + 4'd2);
      5'd6:  r = mk(MC_S + 4'd1, MP_E1 + 4'd2, 1'b0, 1'b0, DST_Q);
      5'd7:  r = mk(MC_S + 4'd2, MP_E1 + 4'd1, 1'b1, 1'b1, DST_Q);
      5'd8:  r = mk(MC_S + 4'd2, MP_E1 + 4'd0, 1'b0, 1'b0, DST_Q + 4'd1);
      5'd9:  r = mk(MC_S + 4'd0, MP_E1 + 4'd2, 1'b1, 1'b1, DST_Q + 4'd1);
      5'd10: r = mk(MC_S + 4'd0, MP_E1 + 4'd1, 1'b0, 1'b0, DST_Q + 4'd2);
      5'd11: r = mk(MC_S + 4'd1, MP_E1 + 4'd0, 1'b1, 1'b1, DST_Q + 4'd2);
      5'd12: r = mk(MC_P + 4'd0, MP_E1 + 4'd0, 1'b0, 1'b0, DST_DET);
      5'd13: r = mk(MC_P + 4'd1, MP_E1 + 4'd1, 1'b0, 1'b0, DST_DET);
      5'd14: r = mk(MC_P + 4'd2, MP_E1 + 4'd2, 1'b0, 1'b1, DST_DET);
      5'd15: r = mk(MC_Q + 4'd0, MP_E2 + 4'd0, 1'b0, 1'b0, DST_NT);
      5'd16: r = mk(MC_Q + 4'd1, MP_E2 + 4'd1, 1'b0, 1'b0, DST_NT);
      5'd17: r = mk(MC_Q + 4'd2, MP_E2 + 4'd2, 1'b0, 1'b1, DST_NT);
      5'd18: r = mk(MC_P + 4'd0, MP_S + 4'd0, 1'b0, 1'b0, DST_NU);
      5'd19: r = mk(MC_P + 4'd1, MP_S + 4'd1, 1'b0, 1'b0, DST_NU);
      5'd20: r = mk(MC_P + 4'd2, MP_S + 4'd2, 1'b0, 1'b1, DST_NU);
      5'd21: r = mk(MC_Q + 4'd0, MP_DIR + 4'd0, 1'b0, 1'b0, DST_NV);
      5'd22: r = mk(MC_Q + 4'd1, MP_DIR + 4'd1, 1'b0, 1'b0, DST_NV);
      5'd23: r = mk(MC_Q + 4'd2, MP_DIR + 4'd2, 1'b0, 1'b1, DST_NV);
      default: r = mk(MC_DIR, MP_E1, 1'b0, 1'b0, DST_P);
    endcase
    return r;
  endfunction

endpackage

[rtl/rtc_front.sv]
module rtc_front import rtc_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [COORD_W-1:0]         cfg_data,
  input  tri_in_t                    tri_in,
  output work_t                      work,
  output logic [2:0][COORD_W-1:0]    dir
);

  logic [2:0][COORD_W-1:0] orig;
  logic [2:0][COORD_W-1:0] v0, v1, v2;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      orig <= '0;
      dir  <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ORIG_X: orig[0] <= cfg_data;
        CFG_ORIG_Y: orig[1] <= cfg_data;
        CFG_ORIG_Z: orig[2] <= cfg_data;
        CFG_DIR_X:  dir[0]  <= cfg_data;
        CFG_DIR_Y:  dir[1]  <= cfg_data;
        CFG_DIR_Z:  dir[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign v0 = {tri_in.vert0_z, tri_in.vert0_y, tri_in.vert0_x};
  assign v1 = {tri_in.vert1_z, tri_in.vert1_y, tri_in.vert1_x};
  assign v2 = {tri_in.vert2_z, tri_in.vert2_y, tri_in.vert2_x};

  // edges and origin offset, sign-extended by one bit so they never wrap
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      work.e1[k] = {v1[k][COORD_W-1], v1[k]} - {v0[k][COORD_W-1], v0[k]};
      work.e2[k] = {v2[k][COORD_W-1], v2[k]} - {v0[k][COORD_W-1], v0[k]};
      work.s[k]  = {orig[k][COORD_W-1], orig[k]} - {v0[k][COORD_W-1], v0[k]};
    end
    work.id   = tri_in.tri_id;
    work.last = tri_in.end_of_search;
  end

endmodule

[rtl/rtc_queue.sv]
module rtc_queue import rtc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push,
  input  work_t din,
  output logic  full,
  input  logic  pop,
  output work_t dout,
  output logic  empty
);

  work_t               entries [QDEPTH];
  logic [QPTR_W-1:0]   wptr, rptr;
  logic [QCNT_W-1:0]   count;
  logic                do_push, do_pop;

  assign full    = count == QCNT_W'(QDEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + 1'b1;
      if (do_pop)  rptr <= rptr + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wptr] <= din;
  end

endmodule

[rtl/rtc_div.sv]
module rtc_div import rtc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [ACC_W-1:0] num,
  input  logic [ACC_W-1:0] den,
  input  logic [Q_W-1:0]   cap,
  output logic             done,
  output logic [Q_W-1:0]   quo
);

  logic              busy;
  logic [DCNT_W-1:0] cnt;
  logic [NUM_W-1:0]  nsh;
  logic [ACC_W:0]    rem, rem_sh;
  logic [ACC_W-1:0]  dreg;
  logic [Q_W-1:0]    capreg, q;
  logic              ovf, ge;

  assign rem_sh = {rem[ACC_W-1:0], nsh[NUM_W-1]};
  assign ge     = rem_sh >= {1'b0, dreg};
  assign quo    = (ovf || q > capreg) ? capreg : q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DCNT_W'(NUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // restoring division, one quotient bit a cycle; bits above Q_W only flag overflow
  always_ff @(posedge clk) begin
    if (start) begin
      nsh    <= {num, {FRAC_BITS{1'b0}}};
      rem    <= '0;
      dreg   <= den;
      capreg <= cap;
      q      <= '0;
      ovf    <= 1'b0;
      cnt    <= '0;
    end else if (busy) begin
      rem <= ge ? rem_sh - {1'b0, dreg} : rem_sh;
      q   <= {q[Q_W-2:0], ge};
      ovf <= ovf | q[Q_W-1];
      nsh <= {nsh[NUM_W-2:0], 1'b0};
      cnt <= cnt + 1'b1;
    end
  end

endmodule

[rtl/rtc_back.sv]
module rtc_back import rtc_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    q_empty,
  input  work_t                   q_head,
  output logic                    q_pop,
  input  logic [2:0][COORD_W-1:0] dir,
  output hit_out_t                out_data,
  output logic                    empty,
  input  logic                    pop
);

  back_state_t         state, state_next;
  logic [MC_W-1:0]     mc [12];
  logic [DIFF_W-1:0]   mp [12];
  logic [ID_BITS-1:0]  id;
  logic                last;
  logic [STEP_W-1:0]   step;
  logic [BIT_W-1:0]    bitcnt;
  logic [ACC_W-1:0]    acc, acc_sum, mcsh;
  logic [DIFF_W-1:0]   mpsh;
  logic [ACC_W-1:0]    det, nt, nu, nv;
  logic                det_zero, front_face, hit, hit_now;
  logic [1:0]          div_idx;
  logic [Q_W-1:0]      tq, uq, vq;
  logic [Q_W-1:0]      best_distance, best_d_new;
  logic [ID_BITS-1:0]  best_id, best_id_new;
  logic                any_hit, any_new, closer_now;
  logic                out_valid, out_load, div_start, div_done, sub;
  logic [ACC_W-1:0]    div_num;
  logic [Q_W-1:0]      div_cap, div_quo;
  step_t               cur;

  localparam logic [BIT_W-1:0]  BIT_LAST  = BIT_W'(DIFF_W - 1);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(NSTEPS - 1);

  assign cur   = step_rom(step);
  assign empty = !out_valid;

  // sign bit of the multiplier weighs negative
  assign sub     = cur.neg ^ (bitcnt == BIT_LAST);
  assign acc_sum = mpsh[0] ? (sub ? acc - mcsh : acc + mcsh) : acc;

  assign hit_now = !det_zero && !nt[ACC_W-1] && !nu[ACC_W-1] && !nv[ACC_W-1]
                   && det >= nu + nv;

  assign div_num = (div_idx == 2'd0) ? nt : (div_idx == 2'd1) ? nu : nv;
  assign div_cap = (div_idx == 2'd0) ? DIST_CAP : BARY_CAP;

  assign closer_now  = hit && tq < best_distance;
  assign best_d_new  = closer_now ? tq : best_distance;
  assign best_id_new = closer_now ? id : best_id;
  assign any_new     = any_hit | hit;

  rtc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (det),
    .cap   (div_cap),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    state_next = state;
    case (state)
      B_IDLE:     if (!q_empty) state_next = B_LOAD;
      B_LOAD:     state_next = B_MAC;
      B_MAC: begin
        if (bitcnt == BIT_LAST) state_next = (step == STEP_LAST) ? B_NORM : B_LOAD;
      end
      B_NORM:     state_next = B_CHECK;
      B_CHECK:    state_next = hit_now ? B_DIV_GO : B_DONE;
      B_DIV_GO:   state_next = B_DIV_WAIT;
      B_DIV_WAIT: begin
        if (div_done) state_next = (div_idx == 2'd2) ? B_DONE : B_DIV_GO;
      end
      B_DONE:     if (!out_valid || pop) state_next = B_IDLE;
      default:    state_next = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop     = (state == B_IDLE) && !q_empty;
    div_start = state == B_DIV_GO;
    out_load  = (state == B_DONE) && (!out_valid || pop);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= B_IDLE;
      out_valid     <= 1'b0;
      best_distance <= '1;
      best_id       <= '0;
      any_hit       <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      if (out_load) begin
        if (last) begin
          best_distance <= '1;
          best_id       <= '0;
          any_hit       <= 1'b0;
        end else begin
          best_distance <= best_d_new;
          best_id       <= best_id_new;
          any_hit       <= any_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        if (q_pop) begin
          for (int k = 0; k < 3; k++) begin
            mc[k]     <= {{(MC_W-COORD_W){dir[k][COORD_W-1]}}, dir[k]};
            mc[3 + k] <= {{(MC_W-DIFF_W){q_head.s[k][DIFF_W-1]}}, q_head.s[k]};
            mp[k]     <= q_head.e1[k];
            mp[3 + k] <= q_head.e2[k];
            mp[6 + k] <= q_head.s[k];
            mp[9 + k] <= {dir[k][COORD_W-1], dir[k]};
          end
          id      <= q_head.id;
          last    <= q_head.last;
          step    <= '0;
          bitcnt  <= '0;
          acc     <= '0;
          div_idx <= '0;
        end
      end
      B_LOAD: begin
        mcsh <= {{(ACC_W-MC_W){mc[cur.mc_sel][MC_W-1]}}, mc[cur.mc_sel]};
        mpsh <= mp[cur.mp_sel];
      end
      B_MAC: begin
        mcsh   <= {mcsh[ACC_W-2:0], 1'b0};
        mpsh   <= {1'b0, mpsh[DIFF_W-1:1]};
        bitcnt <= bitcnt + 1'b1;
        acc    <= acc_sum;
        if (bitcnt == BIT_LAST) begin
          bitcnt <= '0;
          step   <= step + 1'b1;
          if (cur.last) begin
            acc <= '0;
            if (cur.dst < DST_DET) begin
              mc[MC_P + cur.dst] <= acc_sum[MC_W-1:0];
            end else begin
              case (cur.dst)
                DST_DET: det <= acc_sum;
                DST_NT:  nt  <= acc_sum;
                DST_NU:  nu  <= acc_sum;
                DST_NV:  nv  <= acc_sum;
                default: ;
              endcase
            end
          end
        end
      end
      B_NORM: begin
        det_zero   <= det == '0;
        front_face <= !det[ACC_W-1] && det != '0;
        // fold a negative determinant into the numerators
        if (det[ACC_W-1]) begin
          det <= -det;
          nt  <= -nt;
          nu  <= -nu;
          nv  <= -nv;
        end
      end
      B_CHECK: begin
        hit <= hit_now;
        tq  <= '0;
        uq  <= '0;
        vq  <= '0;
      end
      B_DIV_WAIT: begin
        if (div_done) begin
          case (div_idx)
            2'd0:    tq <= div_quo;
            2'd1:    uq <= div_quo;
            default: vq <= div_quo;
          endcase
          div_idx <= div_idx + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.hit_found         <= hit;
      out_data.closer            <= closer_now;
      out_data.front_face        <= front_face;
      out_data.hit_distance      <= tq[DIST_W-1:0];
      out_data.bary_u            <= uq[BARY_W-1:0];
      out_data.bary_v            <= vq[BARY_W-1:0];
      out_data.best_distance_out <= best_d_new[DIST_W-1:0];
      out_data.best_id_out       <= best_id_new;
      out_data.any_hit_out       <= any_new;
      out_data.search_done       <= last;
    end
  end

endmodule

[rtl/ray_triangle_closest_hit.sv]
// Channel   Handshake              Payload
// -------   ---------------------  --------------------------------------
// input     push / full            in_data  (tri_in_t: vertices, id, last)
// result    empty / pop            out_data (hit_out_t)
// config    cfg_valid / cfg_ready  cfg_index, cfg_data (ray origin, dir)
//
// One triangle at a time goes through a shared serial multiply-accumulate:
// 24 products, each loaded and then built by shift-and-add over 33 multiplier bits.
// A hit adds three restoring divisions (t, u, v) one after another; a miss skips them.
// A two-entry queue holds triangles while the back end works; full rises when it fills.
// A result waits in the output register; the back end holds its next result until popped.
// rst clears the queue, the running best (infinite distance) and the ray registers.
module ray_triangle_closest_hit import rtc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  tri_in_t              in_data,
  output logic                 empty,
  input  logic                 pop,
  output hit_out_t             out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COORD_W-1:0]   cfg_data
);

  work_t                   work, head;
  logic [2:0][COORD_W-1:0] dir;
  logic                    q_empty, q_pop;

  rtc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tri_in    (in_data),
    .work      (work),
    .dir       (dir)
  );

  rtc_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (work),
    .full  (full),
    .pop   (q_pop),
    .dout  (head),
    .empty (q_empty)
  );

  rtc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (head),
    .q_pop    (q_pop),
    .dir      (dir),
    .out_data (out_data),
    .empty    (empty),
    .pop      (pop)
  );

endmodule

[rtl/rtc_checker.sv]
module rtc_checker import rtc_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     full,
  input logic     empty,
  input hit_out_t out_data
);

  a_reset_clear: assert property (@(posedge clk) rst |=> empty && !full)
    else $error("queues not clear after reset");

  a_closer_hit: assert property (@(posedge clk) disable iff (rst)
    !empty && out_data.closer |-> out_data.hit_found
      && out_data.best_distance_out == out_data.hit_distance)
    else $error("closer result without matching hit");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    !empty && !out_data.hit_found |-> out_data.hit_distance == '0
      && out_data.bary_u == '0 && out_data.bary_v == '0)
    else $error("miss carries nonzero distance or barycentrics");

  a_any_hit: assert property (@(posedge clk) disable iff (rst)
    !empty && out_data.hit_found |-> out_data.any_hit_out)
    else $error("hit not reflected in any_hit_out");

endmodule

bind ray_triangle_closest_hit rtc_checker u_chk (.*);
